/* rtl/sobel_pkg.sv */
// Shared types and constants for the 3x3 Sobel edge magnitude core.
// No dependencies; used by every module under rtl/ except sobel_ram.
package sobel_pkg;

    localparam int MAX_LINE_WIDTH   = 1024;
    localparam int MAX_FRAME_HEIGHT = 4096;
    localparam int MIN_DIM          = 3;

    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_LINE_WIDTH);
    localparam int ROW_W   = $clog2(MAX_FRAME_HEIGHT);
    localparam int LW_W    = 11;
    localparam int FH_W    = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;
    localparam int LINE_W  = 2 * PIX_W;   // {older, newer}

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // Per-pixel control carried down the pipeline.
    typedef struct packed {
        logic emit;   // center pixel is interior, produce a result
        logic last;   // last interior result of the frame
    } pix_ctl_t;

endpackage

/* rtl/sobel_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module sobel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read-first: a same-address write is not visible until the next read
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sobel_raster_ctr.sv */
// Raster column/row tracking for the Sobel core: clamps the configured
// geometry and tags each accepted pixel. Depends on sobel_pkg.
module sobel_raster_ctr (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            frame_start,
    input  logic [sobel_pkg::LW_W-1:0]      line_width,
    input  logic [sobel_pkg::FH_W-1:0]      frame_height,
    output logic [sobel_pkg::COL_W-1:0]     col,
    output sobel_pkg::pix_ctl_t             ctl
);

    logic [sobel_pkg::COL_W-1:0] col_reg, col_next;
    logic [sobel_pkg::ROW_W-1:0] row_reg, row_next;
    logic [sobel_pkg::LW_W-1:0]  w_clamp;
    logic [sobel_pkg::FH_W-1:0]  h_clamp;
    logic [sobel_pkg::LW_W-1:0]  w_last_wide;
    logic [sobel_pkg::FH_W-1:0]  h_last_wide;
    logic [sobel_pkg::COL_W-1:0] w_last;
    logic [sobel_pkg::ROW_W-1:0] h_last;
    logic [sobel_pkg::COL_W-1:0] col_cur, col_eff;
    logic [sobel_pkg::ROW_W-1:0] row_cur, row_eff;

    always_comb
    begin
        if (line_width < sobel_pkg::LW_W'(sobel_pkg::MIN_DIM))
            w_clamp = sobel_pkg::LW_W'(sobel_pkg::MIN_DIM);
        else if (line_width > sobel_pkg::LW_W'(sobel_pkg::MAX_LINE_WIDTH))
            w_clamp = sobel_pkg::LW_W'(sobel_pkg::MAX_LINE_WIDTH);
        else
            w_clamp = line_width;

        if (frame_height < sobel_pkg::FH_W'(sobel_pkg::MIN_DIM))
            h_clamp = sobel_pkg::FH_W'(sobel_pkg::MIN_DIM);
        else if (frame_height > sobel_pkg::FH_W'(sobel_pkg::MAX_FRAME_HEIGHT))
            h_clamp = sobel_pkg::FH_W'(sobel_pkg::MAX_FRAME_HEIGHT);
        else
            h_clamp = frame_height;

        w_last_wide = w_clamp - sobel_pkg::LW_W'(1);
        h_last_wide = h_clamp - sobel_pkg::FH_W'(1);
        w_last      = w_last_wide[sobel_pkg::COL_W-1:0];
        h_last      = h_last_wide[sobel_pkg::ROW_W-1:0];

        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
        // a counter left beyond a shrunk geometry acts as the last column/row
        col_eff = (col_cur > w_last) ? w_last : col_cur;
        row_eff = (row_cur > h_last) ? h_last : row_cur;

        ctl.emit = (row_eff >= sobel_pkg::ROW_W'(2)) && (col_eff >= sobel_pkg::COL_W'(2));
        ctl.last = (row_eff == h_last) && (col_eff == w_last);
        col      = col_eff;

        if (col_eff == w_last)
        begin
            col_next = '0;
            row_next = (row_eff == h_last) ? '0 : row_eff + sobel_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_eff + sobel_pkg::COL_W'(1);
            row_next = row_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/sobel_window.sv */
// 3x3 window, gradient stage and output register of the Sobel core.
// Depends on sobel_pkg.
module sobel_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    output logic                  load_ready,
    input  sobel_pkg::pix_t       top,
    input  sobel_pkg::pix_t       mid,
    input  sobel_pkg::pix_t       pix,
    input  sobel_pkg::pix_ctl_t   ctl_in,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] edge_value
    output logic                  m_axis_tlast    // frame_last
);

    sobel_pkg::pix_t     win_reg [3][3];
    logic                s2_valid_reg;
    sobel_pkg::pix_ctl_t s2_ctl_reg;
    logic                out_valid_reg;
    sobel_pkg::pix_t     out_data_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                s2_move;
    logic [9:0]          gxp, gxn, gyp, gyn;
    logic [9:0]          dx, dy;
    logic [7:0]          ax, ay;
    logic [8:0]          sum;
    sobel_pkg::pix_t     mag;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign s2_move    = s2_valid_reg && (!s2_ctl_reg.emit || out_free);
    assign load_ready = !s2_valid_reg || s2_move;

    always_comb
    begin
        gxp = {2'b0, win_reg[0][2]} + {1'b0, win_reg[1][2], 1'b0} + {2'b0, win_reg[2][2]};
        gxn = {2'b0, win_reg[0][0]} + {1'b0, win_reg[1][0], 1'b0} + {2'b0, win_reg[2][0]};
        gyp = {2'b0, win_reg[0][0]} + {1'b0, win_reg[0][1], 1'b0} + {2'b0, win_reg[0][2]};
        gyn = {2'b0, win_reg[2][0]} + {1'b0, win_reg[2][1], 1'b0} + {2'b0, win_reg[2][2]};
        dx  = (gxp >= gxn) ? gxp - gxn : gxn - gxp;
        dy  = (gyp >= gyn) ? gyp - gyn : gyn - gyp;
        ax  = (dx > 10'd255) ? 8'hFF : dx[7:0];
        ay  = (dy > 10'd255) ? 8'hFF : dy[7:0];
        sum = {1'b0, ax} + {1'b0, ay};
        mag = sum[8] ? 8'hFF : sum[7:0];
    end

    // window shifts left; the new column enters at the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (load)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top;
            win_reg[1][2] <= mid;
            win_reg[2][2] <= pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                s2_valid_reg <= 1'b1;
            else if (s2_move)
                s2_valid_reg <= 1'b0;

            if (s2_move && s2_ctl_reg.emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s2_ctl_reg <= ctl_in;
        if (s2_move && s2_ctl_reg.emit)
        begin
            out_data_reg <= mag;
            out_last_reg <= s2_ctl_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* rtl/sobel_edge_magnitude_3x3_core.sv */
// Top level of the 3x3 Sobel edge magnitude core: configuration registers,
// line-store RAM with read/modify/write stage. Depends on sobel_pkg,
// sobel_ram, sobel_raster_ctr and sobel_window.
//
// Usage:
//   Pixels enter in raster order on s_axis (tdata = gray level, tuser =
//   start of frame). One edge magnitude leaves on m_axis for every interior
//   pixel, once its bottom-right neighbour has arrived; m_axis_tlast marks
//   the last interior result of a frame. Border pixels give no transaction.
//   Geometry is set through cfg_we/cfg_index/cfg_data (index 0 = line width,
//   index 1 = frame height), clamped to 3..1024 and 3..4096; write it only
//   while the core is idle.
//   Throughput is one pixel per clock while m_axis is not stalled. The two
//   previous rows sit in one 1024 x 16 RAM, one entry per column, read when
//   a pixel is accepted and written back when the read stage advances; a
//   same-column write-back during a read is forwarded. A result passes the
//   RAM read stage, the window and gradient stage and the output register.
//   Reset clears counters, window and pipeline valids and restores 640x480;
//   the RAM is not cleared, as every entry is written before a result uses it.
//   When m_axis stalls the output register holds, the window and RAM stage
//   fill behind it, and s_axis_tready drops only when all three are full.
module sobel_edge_magnitude_3x3_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] pixel
    input  logic                                s_axis_tuser,   // [0] frame_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [7:0] edge_value
    output logic                                m_axis_tlast,   // frame_last
    input  logic                                cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sobel_pkg::CFG_W-1:0]         cfg_data
);

    logic [sobel_pkg::LW_W-1:0]   line_width_reg;
    logic [sobel_pkg::FH_W-1:0]   frame_height_reg;

    logic                         accept;
    logic [sobel_pkg::COL_W-1:0]  col;
    sobel_pkg::pix_ctl_t          ctl;

    // read stage: pixel waits here for its column of the line store
    logic                         s1_valid_reg;
    sobel_pkg::pix_t              s1_pix_reg;
    logic [sobel_pkg::COL_W-1:0]  s1_col_reg;
    sobel_pkg::pix_ctl_t          s1_ctl_reg;
    logic                         s1_fwd_reg;
    logic [sobel_pkg::LINE_W-1:0] s1_fwd_data_reg;

    logic                         s1_advance;
    logic                         win_ready;
    logic [sobel_pkg::LINE_W-1:0] ram_rdata;
    logic [sobel_pkg::LINE_W-1:0] line_data;
    logic [sobel_pkg::LINE_W-1:0] wr_data;
    sobel_pkg::pix_t              top;
    sobel_pkg::pix_t              mid;
    logic                         fwd_hit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= sobel_pkg::LW_W'(640);
            frame_height_reg <= sobel_pkg::FH_W'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sobel_pkg::CFG_LINE_WIDTH:
                    line_width_reg <= cfg_data[sobel_pkg::LW_W-1:0];
                sobel_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[sobel_pkg::FH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign s1_advance    = s1_valid_reg && win_ready;
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sobel_raster_ctr u_ctr (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (s_axis_tuser),
        .line_width   (line_width_reg),
        .frame_height (frame_height_reg),
        .col          (col),
        .ctl          (ctl)
    );

    // rows shift down one place in the store: older <= newer, newer <= pixel
    assign line_data = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign top       = line_data[sobel_pkg::LINE_W-1:sobel_pkg::PIX_W];
    assign mid       = line_data[sobel_pkg::PIX_W-1:0];
    assign wr_data   = {mid, s1_pix_reg};
    // back-to-back pixels on the same column (frame restart): bypass the RAM
    assign fwd_hit   = s1_advance && (s1_col_reg == col);

    sobel_ram #(
        .WIDTH (sobel_pkg::LINE_W),
        .DEPTH (sobel_pkg::MAX_LINE_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (col),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= s_axis_tdata;
            s1_col_reg      <= col;
            s1_ctl_reg      <= ctl;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= wr_data;
        end
    end

    sobel_window u_win (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_advance),
        .load_ready    (win_ready),
        .top           (top),
        .mid           (mid),
        .pix           (s1_pix_reg),
        .ctl_in        (s1_ctl_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // input backpressure only comes from a full read stage
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> s1_valid_reg)
        else $error("s_axis_tready low with empty read stage");

    // a same-column write during a read must be forwarded to the new pixel
    a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_advance && (s1_col_reg == col)) |=> s1_fwd_reg)
        else $error("line store collision not forwarded");

    // RAM write-back only for a pixel that is actually in the read stage
    a_write_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |-> (s1_valid_reg && win_ready))
        else $error("line store write without valid pixel");

    // an accepted pixel sits in the read stage on the next cycle
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (s1_valid_reg && (s1_col_reg == $past(col))))
        else $error("accepted pixel missing from read stage");

endmodule
